// ===== hdl/prefix_trie_engine_top_macros.svh =====
// Assertion macros used by the trie engine back end.
`ifndef PREFIX_TRIE_ENGINE_TOP_MACROS_SVH
`define PREFIX_TRIE_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PTE_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PTE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PTE_ASSERT_SAME(name, ante, cons, msg)
`define PTE_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== hdl/pte_pkg.sv =====
// Shared types and constants of the trie engine.
`default_nettype none
package pte_pkg;
	localparam int NODE_COUNT    = 1024;
	localparam int ALPHABET_SIZE = 26;
	localparam int NODE_W        = $clog2(NODE_COUNT);
	localparam int FREE_W        = $clog2(NODE_COUNT + 1);
	localparam int LANE_W        = $clog2(ALPHABET_SIZE);
	localparam int CMD_W         = 2;
	localparam int LETTER_W      = 5;
	localparam logic [FREE_W-1:0] FREE_MAX = FREE_W'(NODE_COUNT);

	// work queue between front and back
	localparam int WQ_DEPTH = 2;
	localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
	localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);
	// result queue
	localparam int RQ_DEPTH = 2;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_PREFIX = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// classified letter word
	typedef struct packed {
		cmd_t              cmd;
		logic              letter_ok;
		logic [LANE_W-1:0] lane;
		logic              last;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t word;
	} wq_head_t;

	typedef struct packed {
		logic found;
		logic status;
	} res_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;
endpackage
`default_nettype wire

// ===== hdl/pte_front.sv =====
// Front end: takes letter words, classifies them and queues them for the walker.
`default_nettype none
module pte_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [pte_pkg::CMD_W-1:0]       command,
	input  wire logic [pte_pkg::LETTER_W-1:0]    letter,
	input  wire logic                            last,
	input  wire pte_pkg::back_stat_t             back_stat,
	output pte_pkg::wq_head_t                    head,
	input  wire logic                            take
);
	pte_pkg::work_t                 q_q [pte_pkg::WQ_DEPTH];
	logic [pte_pkg::WQ_PTR_W-1:0]   wr_q, rd_q;
	logic [pte_pkg::WQ_CNT_W-1:0]   cnt_q;
	pte_pkg::work_t                 cls;
	logic                           accept, enq, deq;

	always_comb begin
		cls.cmd       = pte_pkg::cmd_t'(command);
		cls.letter_ok = (32'(letter) < 32'(pte_pkg::ALPHABET_SIZE));
		cls.lane      = pte_pkg::LANE_W'(letter);
		cls.last      = last;
	end

	assign full   = back_stat.clearing || (cnt_q == pte_pkg::WQ_CNT_W'(pte_pkg::WQ_DEPTH));
	assign accept = push && !full;
	// unused command code is dropped here
	assign enq    = accept && (cls.cmd != pte_pkg::CMD_NONE);
	assign deq    = take && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.word  = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= (wr_q == pte_pkg::WQ_PTR_W'(pte_pkg::WQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= (rd_q == pte_pkg::WQ_PTR_W'(pte_pkg::WQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/pte_back.sv =====
// Back end: trie walker with child-link and word-end memories.
`default_nettype none
`include "prefix_trie_engine_top_macros.svh"
module pte_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pte_pkg::wq_head_t   head,
	output logic                     take,
	output pte_pkg::back_stat_t      back_stat,
	output logic                     res_push,
	output pte_pkg::res_t            res,
	input  wire logic                res_full
);
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_MARK
	} state_t;

	state_t                        state_q;
	pte_pkg::work_t                wk_q;
	logic [pte_pkg::NODE_W-1:0]    clr_q;
	logic [pte_pkg::NODE_W-1:0]    cur_q;
	logic [pte_pkg::FREE_W-1:0]    free_q;
	logic                          miss_q, ovf_q;

	logic [pte_pkg::NODE_W-1:0]    link_mem [pte_pkg::NODE_COUNT][pte_pkg::ALPHABET_SIZE];
	logic                          end_mem  [pte_pkg::NODE_COUNT];
	logic [pte_pkg::NODE_W-1:0]    row_q    [pte_pkg::ALPHABET_SIZE];
	logic                          mark_q;

	logic [pte_pkg::NODE_W-1:0]    link, cur_n;
	logic                          miss_n, ovf_n, dead, dead_n, alloc;
	logic                          need_mark, direct_res, look_go;
	logic                          alloc_we, set_mark, mark_rd, rd_en;

	assign back_stat.clearing = (state_q == ST_CLEAR);
	assign take  = (state_q == ST_IDLE) && head.valid;
	assign rd_en = take;

	always_comb begin
		miss_n = miss_q;
		ovf_n  = ovf_q;
		cur_n  = cur_q;
		alloc  = 1'b0;
		dead   = miss_q || ovf_q;
		link   = row_q[wk_q.lane];
		if (!dead) begin
			if (!wk_q.letter_ok) begin
				miss_n = 1'b1;
			end else if (link != '0) begin
				cur_n = link;
			end else if (wk_q.cmd != pte_pkg::CMD_INSERT) begin
				miss_n = 1'b1;
			end else if (free_q >= pte_pkg::FREE_MAX) begin
				ovf_n = 1'b1;
			end else begin
				alloc = 1'b1;
				cur_n = free_q[pte_pkg::NODE_W-1:0];
			end
		end
		dead_n     = miss_n || ovf_n;
		need_mark  = wk_q.last && (wk_q.cmd == pte_pkg::CMD_SEARCH) && !dead_n;
		direct_res = wk_q.last && !need_mark;
		look_go    = (state_q == ST_LOOK) && !(direct_res && res_full);
		alloc_we   = look_go && alloc;
		mark_rd    = look_go && need_mark;
		set_mark   = look_go && wk_q.last && (wk_q.cmd == pte_pkg::CMD_INSERT) && !dead_n;
		res_push   = (look_go && direct_res) || ((state_q == ST_MARK) && !res_full);
		if (state_q == ST_MARK) begin
			res.found  = mark_q;
			res.status = 1'b0;
		end else begin
			res.found  = (wk_q.cmd == pte_pkg::CMD_PREFIX) && !dead_n;
			res.status = (wk_q.cmd == pte_pkg::CMD_INSERT) && ovf_n;
		end
	end

	// child links: one row per node, cleared a row per cycle after reset
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			link_mem[clr_q] <= '{default: '0};
		end else if (alloc_we) begin
			link_mem[cur_q][wk_q.lane] <= free_q[pte_pkg::NODE_W-1:0];
		end
		if (rd_en) begin
			row_q <= link_mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			end_mem[clr_q] <= 1'b0;
		end else if (set_mark) begin
			end_mem[cur_n] <= 1'b1;
		end
		if (mark_rd) begin
			mark_q <= end_mem[cur_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wk_q    <= '0;
			clr_q   <= '0;
			cur_q   <= '0;
			free_q  <= pte_pkg::FREE_W'(1);
			miss_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == pte_pkg::NODE_W'(pte_pkg::NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						wk_q    <= head.word;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (look_go) begin
						if (alloc) begin
							free_q <= free_q + 1'b1;
						end
						if (need_mark) begin
							state_q <= ST_MARK;
						end else if (wk_q.last) begin
							cur_q   <= '0;
							miss_q  <= 1'b0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							cur_q   <= cur_n;
							miss_q  <= miss_n;
							ovf_q   <= ovf_n;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_MARK: begin
					if (!res_full) begin
						cur_q   <= '0;
						miss_q  <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PTE_ASSERT_SAME(a_no_overrun, res_push, !res_full, "result pushed into full queue")
	`PTE_ASSERT_SAME(a_pool_bound, 1'b1, free_q <= pte_pkg::FREE_MAX, "free counter past pool")
	`PTE_ASSERT_NEXT(a_take_look, take, state_q == ST_LOOK, "taken word not looked up")
	`PTE_ASSERT_NEXT(a_alloc_step, alloc_we, free_q == $past(free_q) + 1'b1, "bad allocation")
endmodule
`default_nettype wire

// ===== hdl/pte_res_q.sv =====
// Result queue: holds answer words until popped.
`default_nettype none
module pte_res_q (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            res_push,
	input  wire pte_pkg::res_t   res,
	output logic                 res_full,
	output logic                 empty,
	input  wire logic            pop,
	output logic                 found,
	output logic                 status
);
	pte_pkg::res_t                  q_q [pte_pkg::RQ_DEPTH];
	logic [pte_pkg::RQ_PTR_W-1:0]   wr_q, rd_q;
	logic [pte_pkg::RQ_CNT_W-1:0]   cnt_q;
	logic                           enq, deq;

	assign res_full = (cnt_q == pte_pkg::RQ_CNT_W'(pte_pkg::RQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign enq      = res_push && !res_full;
	assign deq      = pop && !empty;
	assign found    = q_q[rd_q].found;
	assign status   = q_q[rd_q].status;

	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= (wr_q == pte_pkg::RQ_PTR_W'(pte_pkg::RQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= (rd_q == pte_pkg::RQ_PTR_W'(pte_pkg::RQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/prefix_trie_engine_top.sv =====
// Top level of the trie engine: front classifier, walker and result queue.
// Each letter word is taken with a read of the link row, then the child is followed
// or allocated and the link written; the final letter of a search adds a word-end
// mark read. Reset is asynchronous, active low; then both memories are cleared a
// node row per cycle, with full high.
`default_nettype none
module prefix_trie_engine_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// letter words in
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [pte_pkg::CMD_W-1:0]       command,
	input  wire logic [pte_pkg::LETTER_W-1:0]    letter,
	input  wire logic                            last,
	// answer words out
	output logic                                 empty,
	input  wire logic                            pop,
	output logic                                 found,
	output logic                                 status
);
	pte_pkg::wq_head_t    head;
	pte_pkg::back_stat_t  back_stat;
	pte_pkg::res_t        res;
	logic                 take;
	logic                 res_push;
	logic                 res_full;

	// Front: drops unused command codes, checks the letter range and queues
	// two words so a new letter can be taken while the walker is busy.
	pte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.letter    (letter),
		.last      (last),
		.back_stat (back_stat),
		.head      (head),
		.take      (take)
	);

	// Back: one word at a time; reads the current node's link row, follows or
	// allocates a child, and on the last letter builds the answer word.
	pte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.take      (take),
		.back_stat (back_stat),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	// Result queue decouples the walker from the consumer's pop.
	pte_res_q u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.found    (found),
		.status   (status)
	);
endmodule
`default_nettype wire

// ===== tb/prefix_trie_engine_top_tb.sv =====
// Self-checking bench for the trie engine: answer words checked against a trie predictor.
`timescale 1ns / 1ps
module prefix_trie_engine_top_tb;

	localparam int CYCLE_LIMIT = 200000;  // run limit, in cycles
	localparam int LONG_HOLD   = 300;     // receiver back-pressure stretch, in cycles
	localparam int SETTLE      = 40;      // quiet cycles after the last answer

	// one letter word as it crosses the input handshake
	typedef struct packed {
		pte_pkg::cmd_t                cmd;
		logic [pte_pkg::LETTER_W-1:0] letter;
		logic                         last;
	} letter_word_t;

	logic                         clk     = 1'b0;
	logic                         arst_n  = 1'b0;
	logic                         push    = 1'b0;
	logic [pte_pkg::CMD_W-1:0]    command = '0;
	logic [pte_pkg::LETTER_W-1:0] letter  = '0;
	logic                         last    = 1'b0;
	logic                         pop     = 1'b0;
	logic                         full;
	logic                         empty;
	logic                         found;
	logic                         status;

	prefix_trie_engine_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.command(command),
		.letter (letter),
		.last   (last),
		.empty  (empty),
		.pop    (pop),
		.found  (found),
		.status (status)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Trie predictor: its own copy of the link table, end marks, free
	// counter and the shared walk. Updated once per accepted letter word.
	// ------------------------------------------------------------------
	logic [pte_pkg::NODE_W-1:0] link_mem [pte_pkg::NODE_COUNT*pte_pkg::ALPHABET_SIZE];
	bit                         end_mark [pte_pkg::NODE_COUNT];
	logic [pte_pkg::FREE_W-1:0] free_next;
	logic [pte_pkg::NODE_W-1:0] walk_node;
	bit                         walk_missing;
	bit                         walk_overflow;

	pte_pkg::res_t answers_due[$];  // answers owed by the block, oldest first
	letter_word_t  tx_words[$];     // letter words waiting to be pushed

	int unsigned cycle_count = 0;
	int          mismatches  = 0;
	int          queued_items = 0;
	int          tx_idle_pct = 30;
	int          rx_idle_pct = 64;
	bit          hold_asked  = 1'b0;
	bit          hold_done   = 1'b0;
	int          hold_left   = 0;

	// Key store for the stimulus side: every key ever sent as an insert, so
	// later searches and prefix tests can aim at real paths.
	logic [pte_pkg::LETTER_W-1:0] known_letters[$];
	int                           known_at[$];
	int                           known_len[$];

	// Follow or allocate one child link, and on the last letter work out
	// the answer word and return the walk to the root.
	function automatic void walk_trie(pte_pkg::cmd_t c, logic [pte_pkg::LETTER_W-1:0] l,
		logic is_last);
		int                         slot;
		logic [pte_pkg::NODE_W-1:0] child;
		bit                         dead;
		pte_pkg::res_t              ans;
		if (c == pte_pkg::CMD_NONE)
			return;  // unused command: no effect at all, even on a last letter
		if (!walk_missing && !walk_overflow) begin
			if (l >= pte_pkg::ALPHABET_SIZE) begin
				walk_missing = 1'b1;  // letter past 'z' kills the walk for any command
			end else begin
				slot  = int'(walk_node) * pte_pkg::ALPHABET_SIZE + int'(l);
				child = link_mem[slot];
				if (child != '0) begin
					walk_node = child;
				end else if (c != pte_pkg::CMD_INSERT) begin
					walk_missing = 1'b1;
				end else if (free_next >= pte_pkg::FREE_MAX) begin
					walk_overflow = 1'b1;  // pool exhausted: no wrap, rest of key is dead
				end else begin
					link_mem[slot] = free_next[pte_pkg::NODE_W-1:0];
					walk_node      = free_next[pte_pkg::NODE_W-1:0];
					free_next      = free_next + 1'b1;
				end
			end
		end
		if (!is_last)
			return;
		dead = walk_missing || walk_overflow;
		ans  = '0;
		case (c)
			pte_pkg::CMD_INSERT: begin
				if (!dead)
					end_mark[walk_node] = 1'b1;
				ans.status = walk_overflow;
			end
			pte_pkg::CMD_SEARCH: begin
				ans.found = !dead && end_mark[walk_node];
			end
			pte_pkg::CMD_PREFIX: begin
				ans.found = !dead;
			end
			default: begin
			end
		endcase
		answers_due.push_back(ans);
		walk_node     = '0;
		walk_missing  = 1'b0;
		walk_overflow = 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Run limit
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample both handshakes at the rising edge. Answers are
	// checked before the accepted letter is predicted, so a spurious
	// answer can never be matched against an expectation made this edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : mon
		pte_pkg::res_t due;
		if (arst_n) begin
			if (pop && !empty) begin
				if (answers_due.size() == 0) begin
					mismatches++;
					$display("%0t: answer word: expected none, got found %0b status %0b",
						$time, found, status);
				end else begin
					due = answers_due.pop_front();
					if (found !== due.found) begin
						mismatches++;
						$display("%0t: found mismatch: expected %0b, got %0b",
							$time, due.found, found);
					end
					if (status !== due.status) begin
						mismatches++;
						$display("%0t: status mismatch: expected %0b, got %0b",
							$time, due.status, status);
					end
				end
			end
			if (push && !full) begin
				walk_trie(pte_pkg::cmd_t'(command), letter, last);
				void'(tx_words.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: offer the oldest pending letter word at the falling edge,
	// idling at random.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && tx_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
			push    <= 1'b1;
			command <= tx_words[0].cmd;
			letter  <= tx_words[0].letter;
			last    <= tx_words[0].last;
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: random pop, plus one long hold-off counted here so the
	// block backs up and raises full while the driver keeps offering.
	always @(negedge clk) begin
		if (hold_asked && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void put(pte_pkg::cmd_t c, int unsigned l, bit e);
		letter_word_t w;
		w.cmd    = c;
		w.letter = pte_pkg::LETTER_W'(l);
		w.last   = e;
		tx_words.push_back(w);
		if (c != pte_pkg::CMD_NONE)
			queued_items++;
	endfunction

	// Replay the first len letters of stored key k under one command.
	function automatic void replay_known(pte_pkg::cmd_t c, int k, int len);
		for (int i = 0; i < len; i++)
			put(c, known_letters[known_at[k] + i], i == len - 1);
	endfunction

	// Block until every pending word is taken and every answer has come.
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (tx_words.size() != 0 || answers_due.size() != 0);
	endtask

	// Mostly well-formed keys with random content: fresh inserts, hits and
	// near-misses on stored keys, plus noise (bad letters, unused command,
	// commands mixed inside one key).
	task automatic gen_mix(int count, int fresh_pct, int maxlen);
		int            target;
		int            k;
		int            len;
		int            bad_at;
		int            start;
		pte_pkg::cmd_t c;
		target = queued_items + count;
		while (queued_items < target) begin
			if ($urandom_range(0, 99) < fresh_pct || known_at.size() == 0) begin
				len   = $urandom_range(1, maxlen);
				start = known_letters.size();
				for (int i = 0; i < len; i++) begin
					known_letters.push_back(
						pte_pkg::LETTER_W'($urandom_range(0, pte_pkg::ALPHABET_SIZE - 1)));
					put(pte_pkg::CMD_INSERT, known_letters[start + i], i == len - 1);
				end
				known_at.push_back(start);
				known_len.push_back(len);
			end else begin
				k   = $urandom_range(0, known_at.size() - 1);
				len = known_len[k];
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						// whole key, sometimes one letter short (no end mark there)
						if (len > 1 && $urandom_range(0, 3) == 0)
							replay_known(pte_pkg::CMD_SEARCH, k, len - 1);
						else
							replay_known(pte_pkg::CMD_SEARCH, k, len);
					end
					3, 4: replay_known(pte_pkg::CMD_PREFIX, k, $urandom_range(1, len));
					5: replay_known(pte_pkg::CMD_INSERT, k, len);
					6: begin
						// random short key, usually a miss
						len = $urandom_range(1, 4);
						c   = $urandom_range(0, 1) ? pte_pkg::CMD_SEARCH : pte_pkg::CMD_PREFIX;
						for (int i = 0; i < len; i++)
							put(c, $urandom_range(0, pte_pkg::ALPHABET_SIZE - 1), i == len - 1);
					end
					7: begin
						// one letter past 'z' somewhere in the key
						bad_at = $urandom_range(0, len - 1);
						c      = pte_pkg::cmd_t'($urandom_range(0, 2));
						for (int i = 0; i < len; i++)
							put(c, (i == bad_at) ? $urandom_range(pte_pkg::ALPHABET_SIZE, 31)
								: known_letters[known_at[k] + i], i == len - 1);
					end
					8: begin
						// shared walk, each letter under its own command
						for (int i = 0; i < len; i++)
							put(pte_pkg::cmd_t'($urandom_range(0, 2)),
								known_letters[known_at[k] + i], i == len - 1);
					end
					default: begin
						// unused-command words scattered through a search
						for (int i = 0; i < len; i++) begin
							if ($urandom_range(0, 1))
								put(pte_pkg::CMD_NONE, $urandom_range(0, 31),
									bit'($urandom_range(0, 1)));
							put(pte_pkg::CMD_SEARCH, known_letters[known_at[k] + i],
								i == len - 1);
						end
					end
				endcase
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main
		int rounds;
		// predictor mirrors the cleared tables after reset
		for (int i = 0; i < pte_pkg::NODE_COUNT * pte_pkg::ALPHABET_SIZE; i++)
			link_mem[i] = '0;
		for (int i = 0; i < pte_pkg::NODE_COUNT; i++)
			end_mark[i] = 1'b0;
		free_next     = pte_pkg::FREE_W'(1);
		walk_node     = '0;
		walk_missing  = 1'b0;
		walk_overflow = 1'b0;

		// directed keys; letters are 0 for 'a' up to 25 for 'z'
		put(pte_pkg::CMD_INSERT, 0, 1);                                  // "a"
		put(pte_pkg::CMD_SEARCH, 0, 1);                                  // hit
		put(pte_pkg::CMD_INSERT, 25, 0); put(pte_pkg::CMD_INSERT, 0, 0);
		put(pte_pkg::CMD_INSERT, 25, 1);                                 // "zaz"
		put(pte_pkg::CMD_SEARCH, 25, 0); put(pte_pkg::CMD_SEARCH, 0, 1); // path, no end mark
		put(pte_pkg::CMD_SEARCH, 25, 0); put(pte_pkg::CMD_SEARCH, 0, 0);
		put(pte_pkg::CMD_SEARCH, 25, 1);
		put(pte_pkg::CMD_PREFIX, 1, 0); put(pte_pkg::CMD_PREFIX, 2, 1);  // missing path
		put(pte_pkg::CMD_INSERT, 2, 0); put(pte_pkg::CMD_INSERT, 31, 1); // insert abandoned
		put(pte_pkg::CMD_SEARCH, 2, 1);                                  // node exists, no mark
		put(pte_pkg::CMD_SEARCH, 26, 1);                                 // letter past 'z'
		put(pte_pkg::CMD_INSERT, 7, 0); put(pte_pkg::CMD_PREFIX, 8, 1);  // mixed, dead prefix
		put(pte_pkg::CMD_SEARCH, 0, 0); put(pte_pkg::CMD_INSERT, 1, 1);  // mixed, makes "ab"
		put(pte_pkg::CMD_SEARCH, 0, 0); put(pte_pkg::CMD_SEARCH, 1, 1);
		put(pte_pkg::CMD_INSERT, 3, 0); put(pte_pkg::CMD_NONE, 9, 1);    // unused cmd ignored
		put(pte_pkg::CMD_INSERT, 4, 1);
		put(pte_pkg::CMD_PREFIX, 3, 0); put(pte_pkg::CMD_PREFIX, 4, 1);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// phase 1: sender idles 30%, receiver 64%
		gen_mix(50, 40, 8);
		wait_drained();

		// phase 2: the other way round, and long fresh inserts until the
		// node pool runs dry; the drains here are the sender pauses
		tx_idle_pct = 64;
		rx_idle_pct = 30;
		rounds      = 0;
		while (free_next < pte_pkg::FREE_MAX && rounds < 40) begin
			gen_mix(60, 97, 30);
			wait_drained();
			rounds++;
		end
		gen_mix(20, 50, 8);  // pool is full now: fresh inserts report status 1
		wait_drained();

		// phase 3: no idling, with the long receiver hold-off up front
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_asked  = 1'b1;
		gen_mix(40, 40, 8);
		wait_drained();

		repeat (SETTLE) @(posedge clk);
		#1;
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
